// File: hdl/rtcchk_pkg.sv
package rtcchk_pkg;

  localparam int QDEPTH_DEF = 2;

  localparam logic [7:0] STALE_LIMIT_RST   = 8'd4;
  localparam logic       WITNESS_ARMED_RST = 1'b0;
  localparam logic [7:0] WITNESS_VALUE_RST = 8'd215;

  localparam logic [7:0] SEC_MASK  = 8'h7F;
  localparam logic [7:0] MIN_MASK  = 8'h7F;
  localparam logic [7:0] HOUR_MASK = 8'h3F;
  localparam logic [7:0] DAY_MASK  = 8'h3F;
  localparam logic [7:0] WDAY_MASK = 8'h07;
  localparam logic [7:0] MON_MASK  = 8'h1F;
  localparam logic [6:0] LEAP_DAY  = 7'd29;

  typedef enum logic [1:0] {
    CFG_STALE_LIMIT   = 2'd0,
    CFG_WITNESS_ARMED = 2'd1,
    CFG_WITNESS_VALUE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_NEVER      = 2'd0,
    ST_RELIABLE   = 2'd1,
    ST_MUTE       = 2'd2,
    ST_UNRELIABLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OC_ACCEPTED  = 2'd0,
    OC_BUS_ERROR = 2'd1,
    OC_REJECTED  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic       ok;
    logic       guard_ok;
    logic       witness_lost;
    logic       stop;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [2:0] wday;
    logic [3:0] mon;
    logic [6:0] year;
  } poll_t;

  typedef struct packed {
    status_t    status;
    outcome_t   outcome;
    logic       witness_lost;
    logic       recovered;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [2:0] wday;
    logic [3:0] mon;
    logic [6:0] year;
    logic       stop;
  } result_t;

endpackage

// File: hdl/rtcchk_fifo.sv
module rtcchk_fifo
  import rtcchk_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULLCNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULLCNT)
    else $error("queue count beyond depth");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == FULLCNT) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: hdl/rtcchk_front.sv
module rtcchk_front
  import rtcchk_pkg::*;
(
  input  logic       guard_ok,
  input  logic [7:0] witness_read,
  input  logic       burst_ok,
  input  logic [7:0] sec_raw,
  input  logic [7:0] min_raw,
  input  logic [7:0] hour_raw,
  input  logic [7:0] day_raw,
  input  logic [7:0] wday_raw,
  input  logic [7:0] month_raw,
  input  logic [7:0] year_raw,
  input  logic [7:0] sec_reread,
  input  logic       witness_armed,
  input  logic [7:0] witness_value,
  output poll_t      poll
);

  function automatic logic bcd_valid(input logic [7:0] v);
    return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
  endfunction

  function automatic logic [6:0] bcd_value(input logic [7:0] v);
    logic [6:0] hi;
    logic [6:0] lo;
    hi = {3'b000, v[7:4]};
    lo = {3'b000, v[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  function automatic logic [6:0] month_len(input logic [3:0] mo);
    logic [6:0] len;
    case (mo)
      4'd2:    len = 7'd29;
      4'd4:    len = 7'd30;
      4'd6:    len = 7'd30;
      4'd9:    len = 7'd30;
      4'd11:   len = 7'd30;
      default: len = 7'd31;
    endcase
    return len;
  endfunction

  logic [7:0] m_sec, m_min, m_hour, m_day, m_wday, m_mon;
  logic [6:0] s, mi, h, d, w, mo, y;
  logic       bus_ok, digits_ok, date_ok, time_ok;

  always_comb begin
    m_sec  = sec_raw & SEC_MASK;
    m_min  = min_raw & MIN_MASK;
    m_hour = hour_raw & HOUR_MASK;
    m_day  = day_raw & DAY_MASK;
    m_wday = wday_raw & WDAY_MASK;
    m_mon  = month_raw & MON_MASK;

    s  = bcd_value(m_sec);
    mi = bcd_value(m_min);
    h  = bcd_value(m_hour);
    d  = bcd_value(m_day);
    w  = bcd_value(m_wday);
    mo = bcd_value(m_mon);
    y  = bcd_value(year_raw);

    bus_ok    = burst_ok && (sec_reread == sec_raw);
    digits_ok = bcd_valid(m_sec) && bcd_valid(m_min) && bcd_valid(m_hour) &&
                bcd_valid(m_day) && bcd_valid(m_wday) && bcd_valid(m_mon) &&
                bcd_valid(year_raw);
    date_ok   = (mo >= 7'd1) && (mo <= 7'd12) && (d >= 7'd1) &&
                (d <= month_len(mo[3:0])) &&
                !((mo == 7'd2) && (d == LEAP_DAY) && (y[1:0] != 2'b00));
    time_ok   = (h <= 7'd23) && (mi <= 7'd59) && (s <= 7'd59);

    poll.ok           = bus_ok && digits_ok && date_ok && time_ok;
    poll.guard_ok     = guard_ok;
    poll.witness_lost = witness_armed && guard_ok && (witness_read != witness_value);
    poll.stop         = sec_raw[7];
    poll.sec          = s[5:0];
    poll.min          = mi[5:0];
    poll.hour         = h[4:0];
    poll.day          = d[4:0];
    poll.wday         = w[2:0];
    poll.mon          = mo[3:0];
    poll.year         = y;
  end

endmodule

// File: hdl/rtcchk_back.sv
module rtcchk_back
  import rtcchk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] stale_limit,
  input  logic       poll_empty,
  input  poll_t      poll,
  output logic       poll_pop,
  input  logic       res_full,
  output logic       res_push,
  output result_t    res
);

  function automatic status_t status_of(input logic ever, input logic [7:0] polls,
                                        input logic [7:0] limit, input logic stop);
    status_t st;
    if (!ever) begin
      st = ST_NEVER;
    end else if (polls >= limit) begin
      st = ST_MUTE;
    end else if (stop) begin
      st = ST_UNRELIABLE;
    end else begin
      st = ST_RELIABLE;
    end
    return st;
  endfunction

  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [4:0] day_r, day_nxt;
  logic [2:0] wday_r, wday_nxt;
  logic [3:0] mon_r, mon_nxt;
  logic [6:0] year_r, year_nxt;
  logic       stop_r, stop_nxt;
  logic       ever_r, ever_nxt;
  logic [7:0] polls_r, polls_nxt;
  logic [7:0] polls_inc;
  logic       go;
  status_t    status_pre, after;

  assign go       = !poll_empty && !res_full;
  assign poll_pop = go;
  assign res_push = go;

  always_comb begin
    polls_inc  = (polls_r == 8'hFF) ? polls_r : polls_r + 8'd1;
    status_pre = status_of(ever_r, polls_inc, stale_limit, stop_r);

    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    wday_nxt  = wday_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    stop_nxt  = stop_r;
    ever_nxt  = ever_r;
    polls_nxt = polls_inc;
    if (poll.ok) begin
      sec_nxt   = poll.sec;
      min_nxt   = poll.min;
      hour_nxt  = poll.hour;
      day_nxt   = poll.day;
      wday_nxt  = poll.wday;
      mon_nxt   = poll.mon;
      year_nxt  = poll.year;
      stop_nxt  = poll.stop;
      ever_nxt  = 1'b1;
      polls_nxt = '0;
    end
    after = status_of(ever_nxt, polls_nxt, stale_limit, stop_nxt);
  end

  always_comb begin
    res.status       = after;
    if (poll.ok) begin
      res.outcome = OC_ACCEPTED;
    end else if (poll.guard_ok) begin
      res.outcome = OC_REJECTED;
    end else begin
      res.outcome = OC_BUS_ERROR;
    end
    res.witness_lost = poll.witness_lost;
    res.recovered    = (after == ST_RELIABLE) && (status_pre != ST_RELIABLE);
    res.sec          = sec_nxt;
    res.min          = min_nxt;
    res.hour         = hour_nxt;
    res.day          = day_nxt;
    res.wday         = wday_nxt;
    res.mon          = mon_nxt;
    res.year         = year_nxt;
    res.stop         = stop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      min_r   <= '0;
      hour_r  <= '0;
      day_r   <= '0;
      wday_r  <= '0;
      mon_r   <= '0;
      year_r  <= '0;
      stop_r  <= 1'b1;
      ever_r  <= 1'b0;
      polls_r <= '0;
    end else if (go) begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      wday_r  <= wday_nxt;
      mon_r   <= mon_nxt;
      year_r  <= year_nxt;
      stop_r  <= stop_nxt;
      ever_r  <= ever_nxt;
      polls_r <= polls_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && poll.ok) |=> (polls_r == '0 && ever_r))
    else $error("accepted read did not clear poll count");
  a_ever_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    ever_r |=> ever_r)
    else $error("ever-read flag dropped");
  a_hold_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !poll.ok) |=> ($stable(sec_r) && $stable(day_r) && $stable(stop_r)))
    else $error("held time changed on rejected poll");
  a_never_read: assert property (@(posedge clk) disable iff (!rst_n)
    (!ever_r && stop_r == 1'b1 && sec_r == '0) || ever_r)
    else $error("held time changed before first accepted read");
`endif

endmodule

// File: hdl/rtc_time_read_checker.sv
// rtc time read checker
// input channel: one word per clock poll (raw bcd time registers, seconds
// re-read, witness byte, bus flags); pushed when push is high and full low
// result channel: one word per poll, oldest on the out_ ports while empty is
// low, taken when pop is high and empty low
// config: cfg_we writes cfg_wdata to register cfg_index (0 stale limit,
// 1 witness armed, 2 witness value); write only while no poll is in flight
// front decodes and checks a poll in its push cycle and queues the verdict;
// back applies it to the held time and status and queues the result word
// a pushed poll is registered in the verdict queue; the back end writes its
// result word into the result queue, which shows it on the result ports
// throughput: one poll per cycle while the result queue has room; the back
// end updates the held time and status as it takes each poll
// a stalled receiver fills the result queue, then the verdict queue, and
// then full rises; nothing is dropped
// reset: queues empty, held time zero, oscillator stop set, status never
// read, config registers to their reset values
module rtc_time_read_checker
  import rtcchk_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_guard_ok,
  input  logic [7:0] in_witness_read,
  input  logic       in_burst_ok,
  input  logic [7:0] in_sec_raw,
  input  logic [7:0] in_min_raw,
  input  logic [7:0] in_hour_raw,
  input  logic [7:0] in_day_raw,
  input  logic [7:0] in_wday_raw,
  input  logic [7:0] in_month_raw,
  input  logic [7:0] in_year_raw,
  input  logic [7:0] in_sec_reread,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_status,
  output logic [1:0] out_outcome,
  output logic       out_witness_lost,
  output logic       out_recovered,
  output logic [5:0] out_seconds,
  output logic [5:0] out_minutes,
  output logic [4:0] out_hours,
  output logic [4:0] out_day,
  output logic [2:0] out_weekday,
  output logic [3:0] out_month,
  output logic [6:0] out_year_offset,
  output logic       out_oscillator_stop,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] stale_limit_r;
  logic       witness_armed_r;
  logic [7:0] witness_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_limit_r   <= STALE_LIMIT_RST;
      witness_armed_r <= WITNESS_ARMED_RST;
      witness_value_r <= WITNESS_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STALE_LIMIT:   stale_limit_r   <= cfg_wdata;
        CFG_WITNESS_ARMED: witness_armed_r <= cfg_wdata[0];
        CFG_WITNESS_VALUE: witness_value_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  poll_t      poll_in;
  poll_t      poll_q;
  logic [$bits(poll_t)-1:0] poll_q_bits;
  logic       poll_empty, poll_pop;
  result_t    res_in;
  result_t    res_q;
  logic [$bits(result_t)-1:0] res_q_bits;
  logic       res_full, res_push;

  rtcchk_front u_front (
    .guard_ok      (in_guard_ok),
    .witness_read  (in_witness_read),
    .burst_ok      (in_burst_ok),
    .sec_raw       (in_sec_raw),
    .min_raw       (in_min_raw),
    .hour_raw      (in_hour_raw),
    .day_raw       (in_day_raw),
    .wday_raw      (in_wday_raw),
    .month_raw     (in_month_raw),
    .year_raw      (in_year_raw),
    .sec_reread    (in_sec_reread),
    .witness_armed (witness_armed_r),
    .witness_value (witness_value_r),
    .poll          (poll_in)
  );

  rtcchk_fifo #(
    .WIDTH ($bits(poll_t)),
    .DEPTH (QDEPTH)
  ) u_poll_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (poll_in),
    .full  (full),
    .pop   (poll_pop),
    .dout  (poll_q_bits),
    .empty (poll_empty)
  );

  assign poll_q = poll_t'(poll_q_bits);

  rtcchk_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .stale_limit (stale_limit_r),
    .poll_empty  (poll_empty),
    .poll        (poll_q),
    .poll_pop    (poll_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res_in)
  );

  rtcchk_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q_bits),
    .empty (empty)
  );

  assign res_q               = result_t'(res_q_bits);
  assign out_status          = res_q.status;
  assign out_outcome         = res_q.outcome;
  assign out_witness_lost    = res_q.witness_lost;
  assign out_recovered       = res_q.recovered;
  assign out_seconds         = res_q.sec;
  assign out_minutes         = res_q.min;
  assign out_hours           = res_q.hour;
  assign out_day             = res_q.day;
  assign out_weekday         = res_q.wday;
  assign out_month           = res_q.mon;
  assign out_year_offset     = res_q.year;
  assign out_oscillator_stop = res_q.stop;

endmodule
